/* design/b64le_pkg.sv */
// ----------------------------------------------------------------------------
// b64le_pkg
// shared types, constants and the alphabet lookup for the base64 line encoder
// ----------------------------------------------------------------------------
package b64le_pkg;

  localparam int unsigned LineChars  = 76;
  localparam int unsigned ColW       = 7;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [ColW-1:0] LINE_CHARS = ColW'(LineChars);
  localparam logic [ColW-1:0] GROUP_CHARS = ColW'(4);

  localparam logic [7:0] CHAR_PAD = 8'h3d;  // '='
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;

  localparam logic [2:0] POS_LAST_SYM = 3'd3;
  localparam logic [2:0] POS_CR       = 3'd4;
  localparam logic [2:0] POS_LF       = 3'd5;

  // one command per group: four ready-made characters plus line-break and end flags
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            crlf;
    logic            fin;
  } cmd_t;

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2b;
    end else begin
      r = 8'h2f;
    end
    return r;
  endfunction

endpackage

/* design/b64le_front.sv */
// ----------------------------------------------------------------------------
// b64le_front
// collects bytes into groups, tracks the column and builds output commands
// ----------------------------------------------------------------------------
module b64le_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 final_byte_i,
  output logic                 push_o,
  output b64le_pkg::cmd_t      cmd_o,
  input  logic                 full_i
);
  import b64le_pkg::*;

  logic [7:0]      held0_q, held0_d, held1_q, held1_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [ColW-1:0] col_q, col_d;
  logic [ColW-1:0] col_add;
  logic            accept;
  logic            full_grp;
  logic [7:0]      a, c;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full_grp   = (cnt_q == 2'd2);
  assign col_add    = col_q + GROUP_CHARS;

  // bytes of the padded group once this byte is held
  assign a = (cnt_q == 2'd0) ? data_byte_i : held0_q;
  assign c = (cnt_q == 2'd1) ? data_byte_i : held1_q;

  always_comb begin
    held0_d  = held0_q;
    held1_d  = held1_q;
    cnt_d    = cnt_q;
    col_d    = col_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    cmd_o.fin = final_byte_i;
    if (full_grp) begin
      cmd_o.chars[0] = b64_sym(held0_q[7:2]);
      cmd_o.chars[1] = b64_sym({held0_q[1:0], held1_q[7:4]});
      cmd_o.chars[2] = b64_sym({held1_q[3:0], data_byte_i[7:6]});
      cmd_o.chars[3] = b64_sym(data_byte_i[5:0]);
      // a group ending a line takes its break; a final group mid-line closes it
      cmd_o.crlf     = (col_add >= LINE_CHARS) || final_byte_i;
    end else begin
      cmd_o.chars[0] = b64_sym(a[7:2]);
      if (cnt_q == 2'd0) begin
        cmd_o.chars[1] = b64_sym({a[1:0], 4'd0});
        cmd_o.chars[2] = CHAR_PAD;
      end else begin
        cmd_o.chars[1] = b64_sym({a[1:0], c[7:4]});
        cmd_o.chars[2] = b64_sym({c[3:0], 2'b00});
      end
      cmd_o.chars[3] = CHAR_PAD;
      cmd_o.crlf     = 1'b1;
    end
    if (accept) begin
      push_o = full_grp || final_byte_i;
      if (final_byte_i) begin
        held0_d = '0;
        held1_d = '0;
        cnt_d   = 2'd0;
        col_d   = '0;
      end else if (full_grp) begin
        cnt_d = 2'd0;
        col_d = (col_add >= LINE_CHARS) ? '0 : col_add;
      end else begin
        if (cnt_q == 2'd0) begin
          held0_d = data_byte_i;
        end else begin
          held1_d = data_byte_i;
        end
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held0_q <= '0;
      held1_q <= '0;
      cnt_q   <= '0;
      col_q   <= '0;
    end else begin
      held0_q <= held0_d;
      held1_q <= held1_d;
      cnt_q   <= cnt_d;
      col_q   <= col_d;
    end
  end

endmodule

/* design/b64le_fifo.sv */
// ----------------------------------------------------------------------------
// b64le_fifo
// short command queue between the group builder and the character sender
// ----------------------------------------------------------------------------
module b64le_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64le_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output b64le_pkg::cmd_t cmd_o
);
  import b64le_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/b64le_back.sv */
// ----------------------------------------------------------------------------
// b64le_back
// walks each queued command, sending one character per cycle while not stalled
// ----------------------------------------------------------------------------
module b64le_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  b64le_pkg::cmd_t cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      text_char_o,
  output logic            run_last_o,
  output logic            stream_end_o
);
  import b64le_pkg::*;

  logic [2:0] pos_q, pos_d;
  logic       vld_q, vld_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d, end_q, end_d;
  logic       load, is_last;

  assign load    = !vld_q || out_ready_i;
  assign is_last = cmd_i.crlf ? (pos_q == POS_LF) : (pos_q == POS_LAST_SYM);

  always_comb begin
    pos_d  = pos_q;
    vld_d  = vld_q;
    char_d = char_q;
    last_d = last_q;
    end_d  = end_q;
    pop_o  = 1'b0;
    case (pos_q)
      POS_CR:  char_d = CHAR_CR;
      POS_LF:  char_d = CHAR_LF;
      default: char_d = cmd_i.chars[pos_q[1:0]];
    endcase
    if (load) begin
      vld_d  = !empty_i;
      last_d = is_last;
      end_d  = is_last && cmd_i.fin;
      if (!empty_i) begin
        if (is_last) begin
          pop_o = 1'b1;
          pos_d = '0;
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end
    end else begin
      char_d = char_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vld_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    end_q  <= end_d;
  end

  assign out_valid_o  = vld_q;
  assign text_char_o  = char_q;
  assign run_last_o   = last_q;
  assign stream_end_o = end_q;

endmodule

/* design/base64_line_wrapped_encoder.sv */
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// MIME base64 encoder with CR LF line breaks every 76 characters
// ----------------------------------------------------------------------------
// Input stream: one body byte per word on s_axis_tdata, tlast on the final
// byte of a body. Output stream: one ASCII character per word on m_axis_tdata,
// tlast on the last character caused by an input byte, tuser on the very last
// character of the encoded body.
// A byte that only completes part of a group produces nothing; a byte that
// completes a group produces four characters, or six with a line break. The
// final byte flushes its group, padded if short, and a closing CR LF.
// The first character of a group passes the command queue and then the output
// register after the byte that completes it is accepted. Throughput is set by
// the character sender, which emits one character per cycle while the receiver
// is ready and a command is queued.
// A two-entry command queue separates the byte side from the character side,
// so input keeps flowing while the receiver stalls until the queue is full;
// a stalled output word holds its value.
// Reset clears held bytes, column count, queue and output valid flag.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // final_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] text_char
  output logic       m_axis_tlast,   // run_last
  output logic       m_axis_tuser    // [0] stream_end
);
  import b64le_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic push, full, pop, empty;

  b64le_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .data_byte_i  (s_axis_tdata),
    .final_byte_i (s_axis_tlast),
    .push_o       (push),
    .cmd_o        (front_cmd),
    .full_i       (full)
  );

  b64le_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (queue_cmd)
  );

  b64le_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .cmd_i        (queue_cmd),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .text_char_o  (m_axis_tdata),
    .run_last_o   (m_axis_tlast),
    .stream_end_o (m_axis_tuser)
  );

endmodule
